/* rtl/tracked_object_motion_segmenter_macros.svh */
// assertion macros for the tracked object motion segmenter
`ifndef TRACKED_OBJECT_MOTION_SEGMENTER_MACROS_SVH
`define TRACKED_OBJECT_MOTION_SEGMENTER_MACROS_SVH
// same-cycle implication
`define TOM_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("tom check failed");
// next-cycle implication
`define TOM_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("tom check failed");
`endif

/* rtl/tom_pkg.sv */
// types and constants of the tracked object motion segmenter
package tom_pkg;
  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_MOTION  = 2'd1,
    MODE_STOPPED = 2'd2
  } motion_mode_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SQ1, ST_SQ2, ST_ROOT, ST_DIV, ST_UPD
  } seq_state_t;

  localparam logic [7:0] REG_THRESHOLD = 8'd0;
  localparam logic [7:0] REG_STOP_CNT  = 8'd1;
  localparam logic [7:0] REG_MAX_TIME  = 8'd2;
  localparam logic [7:0] REG_PPI       = 8'd3;

  localparam int ROOT_BITS = 29;
  localparam int RAD_BITS  = 2 * ROOT_BITS;

  typedef struct packed {
    logic        op;
    logic        obj_valid;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic [19:0] frame_time;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  motion_state;
    logic        run_done;
    logic [15:0] run_number;
    logic [15:0] frame_speed;
    logic [15:0] onset_speed;
    logic [15:0] top_speed;
    logic [15:0] peak_x;
    logic [15:0] peak_y;
    logic [23:0] path_length;
    logic [31:0] motion_time;
  } out_word_t;

  typedef struct packed {
    logic [7:0]  index;
    logic [31:0] data;
  } cfg_word_t;
endpackage

/* rtl/tom_chan_if.sv */
// valid/ready channel carrying one word
interface tom_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/tracked_object_motion_segmenter.sv */
// tracked object motion segmenter top level
// lost or invalid words skip to update; frames get speed, and step length if adding distance
// each root and each division runs one bit per cycle in one shared unit
// one word at a time: a new word is taken only when idle, after any output stall
// rst is synchronous: registers take their reset values, no result pending
`include "tracked_object_motion_segmenter_macros.svh"
module tracked_object_motion_segmenter (
  input logic clk,
  input logic rst,
  tom_chan_if.sink   in_ch,
  tom_chan_if.source out_ch,
  tom_chan_if.sink   cfg_ch
);
  import tom_pkg::*;

  logic [15:0] speed_thresh;
  logic [7:0]  stop_frame_count;
  logic [31:0] max_motion_time;
  logic [15:0] pixels_per_inch;

  seq_state_t st, st_next;
  motion_mode_t mode;
  logic        have_previous;
  logic [15:0] previous_x, previous_y;
  logic [7:0]  slow_frames;
  logic [15:0] run_count, start_speed, best_speed, best_x, best_y;
  logic [23:0] distance_sum;
  logic [31:0] time_sum;

  in_word_t    inw;
  logic        phase;
  logic [15:0] speed;
  logic [23:0] step_len;
  logic [33:0] sq;
  logic [RAD_BITS-1:0]  rad;
  logic [31:0] rem;
  logic [ROOT_BITS-1:0] root;
  logic [15:0] drem;
  logic [4:0]  cnt;
  logic        out_valid;
  out_word_t   outw;

  logic        need_work, need_dist, last_step, upd_go;
  logic signed [16:0] sq_a, sq_b;
  logic signed [33:0] sq_aa, sq_bb;
  logic [33:0] sum_next;
  logic [33:0] rtmp, rtrial;
  logic [16:0] dtmp;
  logic [15:0] ppi_eff;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = (st == ST_IDLE);
  assign out_ch.valid = out_valid;
  assign out_ch.data  = outw;

  assign need_work = !in_ch.data.op && in_ch.data.obj_valid;
  assign need_dist = have_previous && (mode == MODE_MOTION);
  assign last_step = (cnt == 5'(ROOT_BITS - 1));
  assign upd_go    = !out_valid || out_ch.ready;
  assign ppi_eff   = (pixels_per_inch == 16'd0) ? 16'd1 : pixels_per_inch;

  always_comb begin
    if (phase) begin
      sq_a = $signed({1'b0, inw.pos_x}) - $signed({1'b0, previous_x});
      sq_b = $signed({1'b0, inw.pos_y}) - $signed({1'b0, previous_y});
    end else begin
      sq_a = 17'(inw.vel_x);
      sq_b = 17'(inw.vel_y);
    end
  end
  assign sq_aa    = sq_a * sq_a;
  assign sq_bb    = sq_b * sq_b;
  assign sum_next = sq + $unsigned(sq_bb);
  assign rtmp   = {rem, rad[RAD_BITS-1:RAD_BITS-2]};
  assign rtrial = {3'b000, root, 2'b01};
  assign dtmp   = {drem, root[ROOT_BITS-1]};

  always_comb begin
    st_next = st;
    unique case (st)
      ST_IDLE: if (in_ch.valid) st_next = need_work ? ST_SQ1 : ST_UPD;
      ST_SQ1:  st_next = ST_SQ2;
      ST_SQ2:  st_next = ST_ROOT;
      ST_ROOT: if (last_step) st_next = ST_DIV;
      ST_DIV:  if (last_step) st_next = (!phase && need_dist) ? ST_SQ1 : ST_UPD;
      ST_UPD:  if (upd_go) st_next = ST_IDLE;
      default: st_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) st <= ST_IDLE;
    else st <= st_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_thresh     <= 16'd512;
      stop_frame_count <= 8'd5;
      max_motion_time  <= 32'd10000000;
      pixels_per_inch  <= 16'd2560;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.data.index)
        REG_THRESHOLD: speed_thresh     <= cfg_ch.data.data[15:0];
        REG_STOP_CNT:  stop_frame_count <= cfg_ch.data.data[7:0];
        REG_MAX_TIME:  max_motion_time  <= cfg_ch.data.data;
        REG_PPI:       pixels_per_inch  <= cfg_ch.data.data[15:0];
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (st)
      ST_IDLE: if (in_ch.valid) begin
        inw      <= in_ch.data;
        phase    <= 1'b0;
        speed    <= 16'd0;
        step_len <= 24'd0;
      end
      ST_SQ1: sq <= $unsigned(sq_aa);
      ST_SQ2: begin
        rad  <= {sum_next, 24'd0};
        rem  <= 32'd0;
        root <= '0;
        cnt  <= 5'd0;
      end
      ST_ROOT: begin
        rad <= rad << 2;
        cnt <= last_step ? 5'd0 : cnt + 5'd1;
        if (rtmp >= rtrial) begin
          rem  <= 32'(rtmp - rtrial);
          root <= {root[ROOT_BITS-2:0], 1'b1};
        end else begin
          rem  <= rtmp[31:0];
          root <= {root[ROOT_BITS-2:0], 1'b0};
        end
        drem <= 16'd0;
      end
      ST_DIV: begin
        cnt <= cnt + 5'd1;
        if (dtmp >= {1'b0, ppi_eff}) begin
          drem <= 16'(dtmp - {1'b0, ppi_eff});
          root <= {root[ROOT_BITS-2:0], 1'b1};
        end else begin
          drem <= dtmp[15:0];
          root <= {root[ROOT_BITS-2:0], 1'b0};
        end
        if (last_step) begin
          phase <= 1'b1;
          if (!phase) speed <= (root[ROOT_BITS-2:15] != '0) ? 16'hffff
                               : {root[14:0], dtmp >= {1'b0, ppi_eff}};
          else step_len <= (root[ROOT_BITS-2:23] != '0) ? 24'hffffff
                           : {root[22:0], dtmp >= {1'b0, ppi_eff}};
        end
      end
      default: ;
    endcase
  end

  // run tracking update
  motion_mode_t mode_n;
  logic        done_n, have_n;
  logic [7:0]  slow_n, slow_inc;
  logic [15:0] run_n, start_n, best_n, bx_n, by_n;
  logic [23:0] ds_n;
  logic [31:0] ts_n;
  logic [24:0] ds_add;
  logic [32:0] ts_add;

  assign ds_add   = {1'b0, distance_sum} + {1'b0, step_len};
  assign ts_add   = {1'b0, time_sum} + {13'd0, inw.frame_time};
  assign slow_inc = (slow_frames == 8'hff) ? slow_frames : slow_frames + 8'd1;

  always_comb begin
    mode_n = mode; done_n = 1'b0; have_n = have_previous;
    slow_n = slow_frames; run_n = run_count; start_n = start_speed;
    best_n = best_speed; bx_n = best_x; by_n = best_y;
    ds_n = distance_sum; ts_n = time_sum;
    if (inw.op) begin
      if (mode == MODE_MOTION) begin
        mode_n = MODE_STOPPED; done_n = 1'b1;
      end
    end else if (!inw.obj_valid) begin
      have_n = 1'b0;
    end else begin
      if (need_dist) begin
        ds_n = ds_add[24] ? 24'hffffff : ds_add[23:0];
        ts_n = ts_add[32] ? 32'hffffffff : ts_add[31:0];
        if (speed > best_speed) begin
          best_n = speed; bx_n = inw.pos_x; by_n = inw.pos_y;
        end
      end
      have_n = 1'b1;
      if (mode != MODE_MOTION) begin
        if (speed > speed_thresh) begin
          mode_n = MODE_MOTION;
          if (run_count != 16'hffff) run_n = run_count + 16'd1;
          start_n = speed; best_n = speed; bx_n = inw.pos_x; by_n = inw.pos_y;
          ds_n = 24'd0; ts_n = 32'd0; slow_n = 8'd0;
        end
      end else if (ts_n >= max_motion_time) begin
        mode_n = MODE_STOPPED; done_n = 1'b1;
      end else if (speed < speed_thresh) begin
        slow_n = slow_inc;
        if (slow_inc >= stop_frame_count) begin
          mode_n = MODE_STOPPED; done_n = 1'b1;
        end
      end else begin
        slow_n = 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_IDLE; have_previous <= 1'b0;
      previous_x <= 16'd0; previous_y <= 16'd0; slow_frames <= 8'd0;
      run_count <= 16'd0; start_speed <= 16'd0; best_speed <= 16'd0;
      best_x <= 16'd0; best_y <= 16'd0; distance_sum <= 24'd0; time_sum <= 32'd0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ch.ready) out_valid <= 1'b0;
      if (st == ST_UPD && upd_go) begin
        mode <= mode_n; have_previous <= have_n; slow_frames <= slow_n;
        if (!inw.op && inw.obj_valid) begin
          previous_x <= inw.pos_x; previous_y <= inw.pos_y;
        end
        run_count <= run_n; start_speed <= start_n; best_speed <= best_n;
        best_x <= bx_n; best_y <= by_n; distance_sum <= ds_n; time_sum <= ts_n;
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (st == ST_UPD && upd_go) begin
      outw.motion_state <= mode_n;
      outw.run_done     <= done_n;
      outw.run_number   <= run_n;
      outw.frame_speed  <= speed;
      outw.onset_speed  <= start_n;
      outw.top_speed    <= best_n;
      outw.peak_x       <= bx_n;
      outw.peak_y       <= by_n;
      outw.path_length  <= ds_n;
      outw.motion_time  <= ts_n;
    end
  end

  `TOM_ASSERT_IMP(a_done_stopped, out_valid && outw.run_done, outw.motion_state == MODE_STOPPED)
  `TOM_ASSERT_NXT(a_accept_busy, in_ch.valid && in_ch.ready, !in_ch.ready)
  `TOM_ASSERT_IMP(a_dist_phase, st == ST_SQ1 && phase, mode == MODE_MOTION && have_previous)
endmodule
